[rtl/core/cau_pkg.sv]
// Shared types, codes, constants and the saturation helper of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int MAX_EXP = 32;
  localparam int EXP_W   = $clog2(MAX_EXP + 1);
  localparam int KW      = (EXP_W > 8) ? EXP_W : 8;
  localparam int DIV_STEPS = 80;
  localparam int DCNT_W  = $clog2(DIV_STEPS);
  localparam int QW      = 35;

  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_POW = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DZ  = 2'd1;
  localparam logic [1:0] STAT_OVF = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_PROD,
    ST_MFIN,
    ST_DCHK,
    ST_DRE,
    ST_DIM,
    ST_PNEXT,
    ST_DONE
  } state_t;

  // Saturate a sign and magnitude to signed 32 bits; bit 32 of the result is the overflow flag.
  function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
    logic [32:0] res;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) res = {1'b1, 32'h8000_0000};
      else res = {1'b0, 32'(~mag[31:0] + 32'd1)};
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
      else res = {1'b0, mag[31:0]};
    end
    return res;
  endfunction

endpackage

[rtl/core/complex_arithmetic_unit_top.sv]
// Top level of the complex arithmetic unit: sequencer, operand registers and output register.
`timescale 1ns / 1ps
// Sequence: add and subtract pass through ST_ADDSUB; multiply runs the cross products through
// the shared multiplier; divide also forms |y|^2 and makes two passes of the shared bit-serial
// divider; exponent zero and unused actions go straight to ST_DONE. Power repeats the multiplication
// on the shared multiplier, plus a reciprocal for a negative exponent; a stalled output holds ST_DONE.
// Throughput: one transaction at a time; in_tready is high only while the sequencer is idle.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid flag.
module complex_arithmetic_unit_top
  import cau_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99], exponent[137:131]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_re[31:0], res_im[63:32], status[65:64]
  output logic [71:0]  out_tdata
);

  // Control state.
  state_t            state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [EXP_W-1:0]  cnt_r, cnt_nxt;
  logic              is_div_r, is_div_nxt;
  logic              neg_exp_r, neg_exp_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers. The x pair is the left operand, y the right one.
  logic [2:0]         act_r, act_nxt;
  logic signed [31:0] x_re_r, x_re_nxt, x_im_r, x_im_nxt;
  logic signed [31:0] y_re_r, y_re_nxt, y_im_r, y_im_nxt;
  logic signed [64:0] acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic [63:0]        den_r, den_nxt;
  logic [31:0]        rre_r, rre_nxt, rim_r, rim_nxt;
  logic               ovf_r, ovf_nxt, dz_r, dz_nxt;
  logic [71:0]        out_data_r, out_data_nxt;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [64:0] prod65;
  logic               div_start, div_done;
  logic [63:0]        div_num;
  logic [QW-1:0]      div_quo;

  logic [63:0]        mag_re, mag_im;
  logic [32:0]        sat_re, sat_im, sat_q_re, sat_q_im;
  logic signed [32:0] sum_re, sum_im;
  logic [KW-1:0]      exp_mag, k_val;
  logic [6:0]         exp_in;
  logic [1:0]         status;

  cau_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  cau_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (den_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  // Product schedule: real cross terms, imaginary cross terms, then |y|^2 for division.
  always_comb begin
    unique case (step_r)
      3'd0:    begin mul_a = x_re_r; mul_b = y_re_r; end
      3'd1:    begin mul_a = x_im_r; mul_b = y_im_r; end
      3'd2:    begin mul_a = x_re_r; mul_b = y_im_r; end
      3'd3:    begin mul_a = x_im_r; mul_b = y_re_r; end
      3'd4:    begin mul_a = y_re_r; mul_b = y_re_r; end
      3'd5:    begin mul_a = y_im_r; mul_b = y_im_r; end
      default: begin mul_a = x_re_r; mul_b = y_re_r; end
    endcase
  end

  assign prod65 = {prod[63], prod};

  // Sign and magnitude of the accumulated sums; the magnitude never exceeds 2^63.
  assign mag_re = acc_re_r[64] ? 64'(-acc_re_r) : acc_re_r[63:0];
  assign mag_im = acc_im_r[64] ? 64'(-acc_im_r) : acc_im_r[63:0];

  // Products are truncated toward zero by shifting the magnitude.
  assign sat_re   = sat32(acc_re_r[64], mag_re >> 16);
  assign sat_im   = sat32(acc_im_r[64], mag_im >> 16);
  assign sat_q_re = sat32(acc_re_r[64], {{(64 - QW){1'b0}}, div_quo});
  assign sat_q_im = sat32(acc_im_r[64], {{(64 - QW){1'b0}}, div_quo});

  assign exp_in  = in_tdata[137:131];
  assign exp_mag = exp_in[6] ? KW'(-{exp_in[6], exp_in}) : KW'(exp_in);
  assign k_val   = (exp_mag > KW'(MAX_EXP)) ? KW'(MAX_EXP) : exp_mag;

  assign status = dz_r ? STAT_DZ : (ovf_r ? STAT_OVF : STAT_OK);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    is_div_nxt    = is_div_r;
    neg_exp_nxt   = neg_exp_r;
    out_valid_nxt = out_valid_r;
    act_nxt       = act_r;
    x_re_nxt      = x_re_r;
    x_im_nxt      = x_im_r;
    y_re_nxt      = y_re_r;
    y_im_nxt      = y_im_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    den_nxt       = den_r;
    rre_nxt       = rre_r;
    rim_nxt       = rim_r;
    ovf_nxt       = ovf_r;
    dz_nxt        = dz_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_num       = mag_re;
    sum_re        = '0;
    sum_im        = '0;
    in_tready     = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt     = in_tdata[2:0];
          x_re_nxt    = in_tdata[34:3];
          x_im_nxt    = in_tdata[66:35];
          y_re_nxt    = in_tdata[98:67];
          y_im_nxt    = in_tdata[130:99];
          neg_exp_nxt = exp_in[6];
          ovf_nxt     = 1'b0;
          dz_nxt      = 1'b0;
          step_nxt    = '0;
          acc_re_nxt  = '0;
          acc_im_nxt  = '0;
          den_nxt     = '0;
          is_div_nxt  = (in_tdata[2:0] == ACT_DIV);
          unique case (in_tdata[2:0])
            ACT_ADD, ACT_SUB: state_nxt = ST_ADDSUB;
            ACT_MUL, ACT_DIV: state_nxt = ST_PROD;
            ACT_POW: begin
              // Power multiplies the running value by a, so y holds a.
              y_re_nxt = in_tdata[34:3];
              y_im_nxt = in_tdata[66:35];
              cnt_nxt  = EXP_W'(k_val - KW'(1));
              if (k_val == '0) begin
                rre_nxt   = ONE_Q;
                rim_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_PNEXT;
              end
            end
            default: begin
              rre_nxt   = '0;
              rim_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_ADDSUB: begin
        if (act_r == ACT_SUB) begin
          sum_re = {x_re_r[31], x_re_r} - {y_re_r[31], y_re_r};
          sum_im = {x_im_r[31], x_im_r} - {y_im_r[31], y_im_r};
        end else begin
          sum_re = {x_re_r[31], x_re_r} + {y_re_r[31], y_re_r};
          sum_im = {x_im_r[31], x_im_r} + {y_im_r[31], y_im_r};
        end
        if (sum_re[32] != sum_re[31]) begin
          ovf_nxt = 1'b1;
          rre_nxt = sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          rre_nxt = sum_re[31:0];
        end
        if (sum_im[32] != sum_im[31]) begin
          ovf_nxt = 1'b1;
          rim_nxt = sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          rim_nxt = sum_im[31:0];
        end
        if ((sum_re[32] != sum_re[31]) || (sum_im[32] != sum_im[31])) ovf_nxt = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_PROD: begin
        // The product issued one step earlier is available now.
        unique case (step_r)
          3'd1:    acc_re_nxt = acc_re_r + prod65;
          3'd2:    acc_re_nxt = is_div_r ? acc_re_r + prod65 : acc_re_r - prod65;
          3'd3:    acc_im_nxt = is_div_r ? acc_im_r - prod65 : acc_im_r + prod65;
          3'd4:    acc_im_nxt = acc_im_r + prod65;
          3'd5:    den_nxt    = den_r + prod[63:0];
          3'd6:    den_nxt    = den_r + prod[63:0];
          default: ;
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == (is_div_r ? 3'd6 : 3'd4)) begin
          state_nxt = is_div_r ? ST_DCHK : ST_MFIN;
        end
      end

      ST_MFIN: begin
        ovf_nxt = ovf_r | sat_re[32] | sat_im[32];
        if (act_r == ACT_POW) begin
          x_re_nxt  = sat_re[31:0];
          x_im_nxt  = sat_im[31:0];
          state_nxt = ST_PNEXT;
        end else begin
          rre_nxt   = sat_re[31:0];
          rim_nxt   = sat_im[31:0];
          state_nxt = ST_DONE;
        end
      end

      ST_DCHK: begin
        if (den_r == '0) begin
          dz_nxt    = 1'b1;
          rre_nxt   = '0;
          rim_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = mag_re;
          state_nxt = ST_DRE;
        end
      end

      ST_DRE: begin
        if (div_done) begin
          rre_nxt   = sat_q_re[31:0];
          ovf_nxt   = ovf_r | sat_q_re[32];
          div_start = 1'b1;
          div_num   = mag_im;
          state_nxt = ST_DIM;
        end
      end

      ST_DIM: begin
        if (div_done) begin
          rim_nxt   = sat_q_im[31:0];
          ovf_nxt   = ovf_r | sat_q_im[32];
          state_nxt = ST_DONE;
        end
      end

      ST_PNEXT: begin
        step_nxt   = '0;
        acc_re_nxt = '0;
        acc_im_nxt = '0;
        den_nxt    = '0;
        if (cnt_r != '0) begin
          cnt_nxt    = cnt_r - EXP_W'(1);
          is_div_nxt = 1'b0;
          state_nxt  = ST_PROD;
        end else if (neg_exp_r) begin
          // Reciprocal: divide one by the running power.
          y_re_nxt   = x_re_r;
          y_im_nxt   = x_im_r;
          x_re_nxt   = ONE_Q;
          x_im_nxt   = '0;
          is_div_nxt = 1'b1;
          state_nxt  = ST_PROD;
        end else begin
          rre_nxt   = x_re_r;
          rim_nxt   = x_im_r;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {6'd0, status, rim_r, rre_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      is_div_r    <= 1'b0;
      neg_exp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      is_div_r    <= is_div_nxt;
      neg_exp_r   <= neg_exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    x_re_r     <= x_re_nxt;
    x_im_r     <= x_im_nxt;
    y_re_r     <= y_re_nxt;
    y_im_r     <= y_im_nxt;
    acc_re_r   <= acc_re_nxt;
    acc_im_r   <= acc_im_nxt;
    den_r      <= den_nxt;
    rre_r      <= rre_nxt;
    rim_r      <= rim_nxt;
    ovf_r      <= ovf_nxt;
    dz_r       <= dz_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Once a transaction is taken, the unit is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // A division by zero always reports a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == STAT_DZ |-> out_tdata[63:0] == 64'd0)
    else $error("division by zero with nonzero result");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DRE || state_r == ST_DIM))
    else $error("divider finished outside a divide state");

  // A status code never takes the unused value.
  a_status_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("invalid status code");

endmodule

[rtl/core/cau_mul.sv]
// Shared signed 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps
module cau_mul
  import cau_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[rtl/core/cau_div.sv]
// Restoring divider, one quotient bit per cycle, giving floor(num * 2^16 / den) clamped.
`timescale 1ns / 1ps
module cau_div
  import cau_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   num,
  input  logic [63:0]   den,
  output logic          done_r,
  output logic [QW-1:0] quo_r
);

  logic              busy_r, busy_nxt;
  logic              done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]       num_r, num_nxt;
  logic [63:0]       den_r, den_nxt;
  logic [64:0]       rem_r, rem_nxt;
  logic [QW-1:0]     quo_nxt;
  logic [64:0]       rem_sh;
  logic [QW-1:0]     quo_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r[63:0], num_r[63]};
    // The quotient stops growing once it is far beyond the 32-bit range.
    quo_sh   = quo_r[QW-1] ? quo_r : {quo_r[QW-2:0], 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS - 1);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = quo_sh | QW'(1);
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = quo_sh;
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule
